FILE: hdl/rsa_modular_exponentiation_assert.svh
// assertion macros shared by the rsa exponentiation modules
`ifndef RSA_MODULAR_EXPONENTIATION_ASSERT_SVH
`define RSA_MODULAR_EXPONENTIATION_ASSERT_SVH

// implication checked on every edge outside reset
`define RME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// types and constants for the rsa modular exponentiation block
// ----------------------------------------------------------------------------
package rme_pkg;
    localparam int MOD_BITS_DEF = 32;
    localparam int WORD_W       = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd2;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              too_wide;
    } t_out_item;
endpackage

FILE: hdl/rme_modmul.sv
// ----------------------------------------------------------------------------
// rme_modmul
// shift-add modular multiplier, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module rme_modmul import rme_pkg::*; #(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOD_BITS-1:0] i_a,
    input  logic [MOD_BITS-1:0] i_b,
    input  logic [MOD_BITS-1:0] i_n,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_p
);
    `include "rsa_modular_exponentiation_assert.svh"

    localparam int CNT_W = $clog2(MOD_BITS + 1);

    logic                r_busy, n_busy;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [MOD_BITS-1:0] r_a, r_b, r_n;
    logic                r_done;
    logic [MOD_BITS:0]   w_dbl, w_d1, w_add, w_d2;

    // operands are below n, so each doubling and each addition needs one compare and subtract
    always_comb begin
        w_dbl = {r_acc, 1'b0};
        w_d1  = (w_dbl >= {1'b0, r_n}) ? w_dbl - {1'b0, r_n} : w_dbl;
        w_add = w_d1 + (r_b[MOD_BITS-1] ? {1'b0, r_a} : '0);
        w_d2  = (w_add >= {1'b0, r_n}) ? w_add - {1'b0, r_n} : w_add;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        if (r_busy) begin
            n_acc = w_d2[MOD_BITS-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(MOD_BITS);
            n_acc  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= r_busy && (r_cnt == CNT_W'(1));
        end
        r_acc <= n_acc;
        if (!r_busy && i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_n <= i_n;
        end else if (r_busy) begin
            r_b <= {r_b[MOD_BITS-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

    `RME_ASSERT_NEXT(a_mm_done_after_last, i_clk, i_rst_n, r_busy && r_cnt == CNT_W'(1), r_done)
    `RME_ASSERT_IMP(a_mm_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `RME_ASSERT_IMP(a_mm_below_n, i_clk, i_rst_n, r_done, r_acc < r_n)
endmodule

FILE: hdl/rme_seq.sv
// ----------------------------------------------------------------------------
// rme_seq
// square-and-multiply sequencer driving the shared modular multiplier
// ----------------------------------------------------------------------------
module rme_seq import rme_pkg::*; #(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_op,
    input  logic [WORD_W-1:0] i_value,
    input  logic [WORD_W-1:0] i_modulus,
    input  logic [WORD_W-1:0] i_exp,
    output logic              o_done,
    output t_out_item         o_item
);
    `include "rsa_modular_exponentiation_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam int RED_W = $clog2(WORD_W + 1);

    logic [2:0]          r_state;
    logic [MOD_BITS-1:0] r_n, r_acc, r_sq;
    logic [WORD_W-1:0]   r_e, r_val;
    logic [RED_W-1:0]    r_rcnt;
    logic [MOD_BITS:0]   r_rem;
    logic                r_op, r_done;
    t_out_item           r_item;
    logic                w_mm_start, w_mm_done;
    logic [MOD_BITS-1:0] w_mm_a, w_mm_b, w_mm_p;
    logic [MOD_BITS:0]   w_rsh, w_red;

    // restoring reduction of the operand: one value bit per cycle
    assign w_rsh = {r_rem[MOD_BITS-1:0], r_val[WORD_W-1]};
    assign w_red = (w_rsh >= {1'b0, r_n}) ? w_rsh - {1'b0, r_n} : w_rsh;

    always_comb begin
        w_mm_start = 1'b0;
        w_mm_a     = r_acc;
        w_mm_b     = r_sq;
        if (r_state == S_STEP && r_e != '0) begin
            w_mm_start = 1'b1;
            if (!r_e[0]) begin
                w_mm_a = r_sq;
            end
        end
    end

    rme_modmul #(.MOD_BITS(MOD_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mm_start),
        .i_a(w_mm_a), .i_b(w_mm_b), .i_n(r_n),
        .o_done(w_mm_done), .o_p(w_mm_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n    <= i_modulus[MOD_BITS-1:0];
                        r_op   <= i_op;
                        r_e    <= i_exp;
                        r_val  <= (i_op == OP_DECRYPT) ? i_value
                                                       : {16'd0, i_value[15:0]};
                        r_rem  <= '0;
                        r_rcnt <= RED_W'(WORD_W);
                        r_acc  <= (i_modulus[MOD_BITS-1:0] == MOD_BITS'(1))
                                  ? '0 : MOD_BITS'(1);
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    if (r_n == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_rem  <= w_red;
                        r_val  <= {r_val[WORD_W-2:0], 1'b0};
                        r_rcnt <= r_rcnt - 1'b1;
                        if (r_rcnt == RED_W'(1)) begin
                            // reduced base becomes the first square operand
                            r_sq    <= w_red[MOD_BITS-1:0];
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    if (r_e == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= r_e[0] ? S_MUL : S_SQR;
                    end
                end
                S_MUL: begin
                    if (w_mm_done) begin
                        r_acc <= w_mm_p;
                        r_e[0] <= 1'b0;
                        r_state <= S_STEP;
                    end
                end
                S_SQR: begin
                    if (w_mm_done) begin
                        r_sq <= w_mm_p;
                        r_e  <= r_e >> 1;
                        r_state <= S_STEP;
                    end
                end
                S_FIN: begin
                    r_item.too_wide <= 1'b0;
                    r_item.result   <= '0;
                    if (r_n != '0) begin
                        if (r_op == OP_DECRYPT && WORD_W'(r_acc) > WORD_W'(16'hFFFF)) begin
                            r_item.too_wide <= 1'b1;
                        end else begin
                            r_item.result <= WORD_W'(r_acc);
                        end
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_item = r_item;

    `RME_ASSERT_NEXT(a_seq_fin_done, i_clk, i_rst_n, r_state == S_FIN, r_done && r_state == S_IDLE)
    `RME_ASSERT_IMP(a_seq_wide_zero, i_clk, i_rst_n, r_done && r_item.too_wide, r_item.result == '0)
    `RME_ASSERT_IMP(a_seq_mm_idle, i_clk, i_rst_n, w_mm_done, r_state == S_MUL || r_state == S_SQR)
endmodule

FILE: hdl/rsa_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation
// rsa encrypt / decrypt by square-and-multiply modular exponentiation
// ----------------------------------------------------------------------------
// usage
//   config channel: write modulus (0), public exponent (1), private exponent
//   (2) while idle; other indexes are dropped. always ready
//   input channel: op and value; one item at a time, ready only when idle
//   and the output register is empty
//   output channel: result and too_wide held in a register until transfer
// operation
//   operand reduction first, then per exponent bit one modular
//   square plus a multiply when the bit is set, each on the single
//   shared shift-add multiplier; the square after the top exponent bit is
//   skipped, so at most 63 products per item
// reset
//   registers return to modulus 1 and zero exponents, pipeline empties
// stall
//   a held result blocks the next input transfer until taken
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation import rme_pkg::*; #(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item
);
    `include "rsa_modular_exponentiation_assert.svh"

    logic [WORD_W-1:0] r_modulus, r_pub_exp, r_priv_exp;
    logic              r_busy, r_out_valid;
    t_out_item         r_out_item;
    logic              w_in_xfer, w_done;
    t_out_item         w_item;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy && !r_out_valid;
    assign w_in_xfer   = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= WORD_W'(1);
            r_pub_exp  <= '0;
            r_priv_exp <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODULUS:  r_modulus  <= i_cfg_data;
                REG_PUB_EXP:  r_pub_exp  <= i_cfg_data;
                REG_PRIV_EXP: r_priv_exp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rme_seq #(.MOD_BITS(MOD_BITS)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_in_xfer),
        .i_op(i_in_item.op), .i_value(i_in_item.value), .i_modulus(r_modulus),
        .i_exp((i_in_item.op == OP_DECRYPT) ? r_priv_exp : r_pub_exp),
        .o_done(w_done), .o_item(w_item)
    );

    // busy from input transfer to result, then the output register holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_done) begin
            r_out_item <= w_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `RME_ASSERT_IMP(a_top_done_busy, i_clk, i_rst_n, w_done, r_busy && !r_out_valid)
    `RME_ASSERT_NEXT(a_top_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)
    `RME_ASSERT_NEXT(a_top_xfer_busy, i_clk, i_rst_n, w_in_xfer, r_busy)
endmodule

FILE: test/rsa_modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation_tb
// checks rsa square-and-multiply exponentiation against a local predictor;
// a directed table covers reset state, zero modulus, zero and full exponents, an
// unused index and a textbook key pair, then random phases vary the key registers
// and the idle and stall patterns on both channels, including one long output hold
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation_tb;
    import rme_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // write must be dropped
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES    = 6000;   // long receiver hold-off

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_item;

    rsa_modular_exponentiation uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // local copy of the key registers, updated on each config transfer
    logic [WORD_W-1:0] key_modulus;
    logic [WORD_W-1:0] key_pub;
    logic [WORD_W-1:0] key_priv;

    t_out_item pending_results[$];
    int        error_count;
    int        sender_idle_pct;
    int        receiver_stall_pct;
    int        hold_left;
    int        quiet_cycles;

    // square-and-multiply from the lsb of the exponent
    function automatic logic [63:0] pow_mod(logic [63:0] base, logic [31:0] expo,
                                            logic [63:0] n);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1 % n;
        sq  = base % n;
        while (expo != 0) begin
            if (expo[0]) begin
                acc = (acc * sq) % n;
            end
            sq   = (sq * sq) % n;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    function automatic t_out_item rsa_result(t_in_item it);
        t_out_item   r;
        logic [63:0] n;
        logic [63:0] v;
        n = {32'd0, key_modulus};
        r = '0;
        if (n != 0) begin
            if (it.op == OP_DECRYPT) begin
                v = pow_mod({32'd0, it.value}, key_priv, n);
                if (v > 64'hFFFF) begin
                    r.too_wide = 1'b1;
                end else begin
                    r.result = v[31:0];
                end
            end else begin
                // encrypt takes the 16-bit plaintext only
                v = pow_mod({48'd0, it.value[15:0]}, key_pub, n);
                r.result = v[31:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // monitor: config copy, expectation queue, result check, watchdog
    always @(posedge i_clk) begin
        t_out_item want;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    REG_MODULUS:  key_modulus = i_cfg_data;
                    REG_PUB_EXP:  key_pub = i_cfg_data;
                    REG_PRIV_EXP: key_priv = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                pending_results.push_back(rsa_result(i_in_item));
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", o_out_item.result, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_item.result !== want.result)
                        report_mismatch("result", o_out_item.result, want.result);
                    if (o_out_item.too_wide !== want.too_wide)
                        report_mismatch("too_wide", 32'(o_out_item.too_wide),
                                        32'(want.too_wide));
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("rsa_modular_exponentiation_tb: done, errors");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic op, logic [WORD_W-1:0] value);
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 12) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_in_item.op    <= op;
        i_in_item.value <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // wait for every expected result; each item yields one
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(65535);
            3: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // directed rows: a config write, or an item with an optional fixed answer
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic                 op;
        logic [WORD_W-1:0]    data;
        bit                   fixed;
        logic [WORD_W-1:0]    want;
        logic                 want_wide;
    } t_row;

    t_row rows[] = '{
        // reset keys: n = 1, so everything is 0
        '{0, REG_MODULUS, OP_ENCRYPT, 32'h0000_0000, 1, 32'd0, 1'b0},
        '{0, REG_MODULUS, OP_DECRYPT, 32'hFFFF_FFFF, 1, 32'd0, 1'b0},
        // zero modulus
        '{1, REG_MODULUS, OP_ENCRYPT, 32'h0000_0000, 0, 32'd0, 1'b0},
        '{0, REG_MODULUS, OP_ENCRYPT, 32'h0000_FFFF, 1, 32'd0, 1'b0},
        '{0, REG_MODULUS, OP_DECRYPT, 32'hFFFF_FFFF, 1, 32'd0, 1'b0},
        // zero exponents give 1
        '{1, REG_MODULUS, OP_ENCRYPT, 32'hFFFF_FFFF, 0, 32'd0, 1'b0},
        '{0, REG_MODULUS, OP_ENCRYPT, 32'hFFFF_FFFF, 1, 32'd1, 1'b0},
        '{0, REG_MODULUS, OP_DECRYPT, 32'h0001_2345, 1, 32'd1, 1'b0},
        // unused index must not touch the keys
        '{1, REG_UNUSED,  OP_ENCRYPT, 32'h0000_0005, 0, 32'd0, 1'b0},
        '{0, REG_MODULUS, OP_ENCRYPT, 32'h0000_0007, 1, 32'd1, 1'b0},
        // full exponents
        '{1, REG_PUB_EXP, OP_ENCRYPT, 32'hFFFF_FFFF, 0, 32'd0, 1'b0},
        '{1, REG_PRIV_EXP, OP_ENCRYPT, 32'hFFFF_FFFF, 0, 32'd0, 1'b0},
        '{0, REG_MODULUS, OP_ENCRYPT, 32'hFFFF_0002, 0, 32'd0, 1'b0},
        '{0, REG_MODULUS, OP_DECRYPT, 32'hFFFF_FFFE, 0, 32'd0, 1'b0},
        '{0, REG_MODULUS, OP_DECRYPT, 32'h0000_0001, 1, 32'd1, 1'b0},
        '{0, REG_MODULUS, OP_DECRYPT, 32'h0000_0000, 1, 32'd0, 1'b0},
        // textbook key n = 61 * 53, e = 17, d = 2753
        '{1, REG_MODULUS, OP_ENCRYPT, 32'd3233, 0, 32'd0, 1'b0},
        '{1, REG_PUB_EXP, OP_ENCRYPT, 32'd17, 0, 32'd0, 1'b0},
        '{1, REG_PRIV_EXP, OP_ENCRYPT, 32'd2753, 0, 32'd0, 1'b0},
        '{0, REG_MODULUS, OP_ENCRYPT, 32'd65, 1, 32'd2790, 1'b0},
        '{0, REG_MODULUS, OP_DECRYPT, 32'd2790, 1, 32'd65, 1'b0},
        '{0, REG_MODULUS, OP_DECRYPT, 32'hFFFF_FFFF, 0, 32'd0, 1'b0},
        '{1, REG_MODULUS, OP_ENCRYPT, 32'h8000_0000, 0, 32'd0, 1'b0},
        '{0, REG_MODULUS, OP_DECRYPT, 32'h7FFF_FFFF, 0, 32'd0, 1'b0},
        '{0, REG_MODULUS, OP_ENCRYPT, 32'hABCD_8001, 0, 32'd0, 1'b0}
    };

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = REG_MODULUS;
        i_cfg_data         = '0;
        i_in_valid         = 1'b0;
        i_in_item          = '0;
        i_out_ready        = 1'b0;
        key_modulus        = 32'd1;
        key_pub            = '0;
        key_priv           = '0;
        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left          = 0;
        quiet_cycles       = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, fixed answers checked here, every item by the monitor
        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                drain();
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                send_item(rows[i].op, rows[i].data);
                if (rows[i].fixed) begin
                    t_out_item r;
                    r = rsa_result(i_in_item);
                    if (r.result !== rows[i].want || r.too_wide !== rows[i].want_wide)
                        report_mismatch("directed answer", r.result, rows[i].want);
                end
            end
        end

        // random phases: no idling, sender idle, receiver stall, both, hold-off
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            sender_idle_pct    = (phase == 1) ? 59 : (phase == 3) ? 8 : 0;
            receiver_stall_pct = (phase == 2) ? 59 : (phase == 3) ? 8 : 0;
            case (phase)
                0: write_reg(REG_MODULUS, 32'hFFFF_FFFF);
                2: write_reg(REG_MODULUS, $urandom_range(2, 65535));
                3: write_reg(REG_MODULUS, $urandom_range(1, 300));
                default: write_reg(REG_MODULUS, $urandom | 32'h8000_0001);
            endcase
            write_reg(REG_PUB_EXP, (phase == 4) ? 32'hFFFF_FFFF : pick_word());
            write_reg(REG_PRIV_EXP, (phase == 0) ? 32'd0 : pick_word());
            if (phase == 4) begin
                @(negedge i_clk);
                hold_left <= HOLD_CYCLES;
            end
            for (int k = 0; k < 52; k++) begin
                send_item(1'($urandom_range(1)), pick_word());
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("rsa_modular_exponentiation_tb: done, clean");
        end else begin
            $display("rsa_modular_exponentiation_tb: done, errors");
        end
        $finish;
    end
endmodule

FILE: rsa_modular_exponentiation.f
+incdir+hdl
hdl/rme_pkg.sv
hdl/rme_modmul.sv
hdl/rme_seq.sv
hdl/rsa_modular_exponentiation.sv
test/rsa_modular_exponentiation_tb.sv
